// ===== src/graph_depth_first_search_assert.svh =====
// assertion macros for the depth-first search block
`ifndef GRAPH_DEPTH_FIRST_SEARCH_ASSERT_SVH
`define GRAPH_DEPTH_FIRST_SEARCH_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define GDFS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("gdfs check failed");

`define GDFS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gdfs check failed");

`define GDFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gdfs check failed");

`else

`define GDFS_ASSERT_ALWAYS(lbl, cond)
`define GDFS_ASSERT_IMPL(lbl, ante, cons)
`define GDFS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== src/gdfs_pkg.sv =====
// shared constants and codes for the depth-first search block
`timescale 1ns / 1ps
`default_nettype none
package gdfs_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int MAX_EDGES_DEF    = 256;
    localparam int OUT_LIMIT        = 32;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_WALK  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic REG_VCOUNT = 1'b0;
    localparam logic REG_MODE   = 1'b1;

    localparam logic [5:0] VCOUNT_RESET = 6'd32;

endpackage
`default_nettype wire

// ===== src/gdfs_head_mem.sv =====
// list head memory with per-vertex valid bits, empty reads as the null marker
`timescale 1ns / 1ps
`default_nettype none
module gdfs_head_mem #(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 256,
    parameter int VW           = $clog2(MAX_VERTICES),
    parameter int EW           = $clog2(MAX_EDGES + 1)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          clr,
    input  wire logic          wr_en,
    input  wire logic [VW-1:0] wr_addr,
    input  wire logic [EW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [VW-1:0] rd_addr,
    output logic      [EW-1:0] rd_data
);

    localparam logic [EW-1:0] NULL_EDGE = EW'(MAX_EDGES);

    logic [EW-1:0]           mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] vld_reg;
    logic [EW-1:0]           rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (clr) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_reg <= vld_reg[rd_addr] ? mem[rd_addr] : NULL_EDGE;
        end
    end

    assign rd_data = rd_reg;

endmodule
`default_nettype wire

// ===== src/gdfs_edge_mem.sv =====
// edge store: target vertex and next link for each stored edge
`timescale 1ns / 1ps
`default_nettype none
module gdfs_edge_mem #(
    parameter int MAX_EDGES = 256,
    parameter int VW        = 5,
    parameter int EW        = $clog2(MAX_EDGES + 1),
    parameter int AW        = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [VW-1:0] wr_tgt,
    input  wire logic [EW-1:0] wr_lnk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [VW-1:0] rd_tgt,
    output logic      [EW-1:0] rd_lnk
);

    logic [VW-1:0] tgt_mem [MAX_EDGES];
    logic [EW-1:0] lnk_mem [MAX_EDGES];
    logic [VW-1:0] tgt_reg;
    logic [EW-1:0] lnk_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tgt_mem[wr_addr] <= wr_tgt;
            lnk_mem[wr_addr] <= wr_lnk;
        end
        if (rd_en) begin
            tgt_reg <= tgt_mem[rd_addr];
            lnk_reg <= lnk_mem[rd_addr];
        end
    end

    assign rd_tgt = tgt_reg;
    assign rd_lnk = lnk_reg;

endmodule
`default_nettype wire

// ===== src/graph_depth_first_search.sv =====
// depth-first search over a graph held as adjacency lists
//
// Input stream (s_*): one request per item; s_tuser holds the kind (add edge,
// start walk, clear graph), s_tdata the vertex operands. Result stream (m_*):
// an add, a clear, an unused kind or a rejected request gives one acknowledgement
// carrying a status; a walk gives one result per visited vertex, in visit order,
// with m_tlast on the final one. Registers vertex_count and order_mode sit on the
// APB port; the user must write them only while the block is idle, and the
// block itself does not enforce this. An add reads the list head, then writes
// the edge and the new head, and for the reverse edge does both again. A clear
// resets all list heads at once. The list head, edge and stack memories each
// have one read port with a registered read. Only one request is in work at a
// time; the next is taken as soon as the last result is in the output register.
// Reset empties all lists and sets vertex_count to 32 and order_mode to 0; the
// edge store needs no clearing pass. A stalled receiver holds the output
// register and the walk waits on it; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none
module graph_depth_first_search
    import gdfs_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // edge_from[4:0], edge_to[9:5], both_ways[10], start_vertex[15:11]
    input  wire logic [15:0] s_tdata,
    // kind[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // vertex[4:0], status[6:5], zero[7]
    output logic [7:0]       m_tdata,
    // visit[0]
    output logic [0:0]       m_tuser,
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

`include "graph_depth_first_search_assert.svh"

    localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int DW  = $clog2(MAX_VERTICES + 1);

    localparam logic [EW-1:0] NULL_EDGE = EW'(MAX_EDGES);
    localparam logic [EW:0]   MAXE_X    = (EW+1)'(MAX_EDGES);
    localparam logic [6:0]    MAXV7     = 7'(MAX_VERTICES);
    localparam logic [DW-1:0] MAXV_D    = DW'(MAX_VERTICES);
    localparam logic [5:0]    LIM       = 6'(OUT_LIMIT);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_ADD_WR1 = 14'b00000000000010,
        S_ADD_RD2 = 14'b00000000000100,
        S_ADD_WR2 = 14'b00000000001000,
        S_ACK     = 14'b00000000010000,
        S_T0_CUR  = 14'b00000000100000,
        S_T0_EDGE = 14'b00000001000000,
        S_T0_HEAD = 14'b00000010000000,
        S_T0_POP  = 14'b00000100000000,
        S_T1_POP  = 14'b00001000000000,
        S_T1_VERT = 14'b00010000000000,
        S_T1_HEAD = 14'b00100000000000,
        S_T1_CUR  = 14'b01000000000000,
        S_T1_EDGE = 14'b10000000000000
    } state_t;

    // flush of the held vertex shares the ack state, told apart by flush_reg
    state_t state_reg, state_next;

    logic [5:0]              vcount_reg;
    logic                    mode_reg;
    logic [EW-1:0]           used_reg, used_next;
    logic [DW-1:0]           depth_reg, depth_next;
    logic [EW-1:0]           cur_reg, cur_next;
    logic [MAX_VERTICES-1:0] vis_reg, vis_next;
    logic [VW-1:0]           pend_reg, pend_next;
    logic                    pend_vld_reg, pend_vld_next;
    logic [5:0]              n_reg, n_next;
    logic [1:0]              status_reg, status_next;
    logic                    flush_reg, flush_next;
    logic [VW-1:0]           afrom_reg, afrom_next;
    logic [VW-1:0]           ato_reg, ato_next;
    logic                    both_reg, both_next;

    logic       out_vld_reg, out_vld_next;
    logic       out_visit_reg, out_visit_next;
    logic [4:0] out_v_reg, out_v_next;
    logic       out_last_reg, out_last_next;
    logic [1:0] out_st_reg, out_st_next;

    logic          hd_clr, hd_wr_en, hd_rd_en;
    logic [VW-1:0] hd_wr_addr, hd_rd_addr;
    logic [EW-1:0] hd_wr_data, hd_rd_data;

    logic           ed_wr_en, ed_rd_en;
    logic [EAW-1:0] ed_wr_addr, ed_rd_addr;
    logic [VW-1:0]  ed_wr_tgt, ed_rd_tgt;
    logic [EW-1:0]  ed_wr_lnk, ed_rd_lnk;

    logic          st_wr_en, st_rd_en;
    logic [VW-1:0] st_wr_addr, st_rd_addr, st_wr_v, st_rd_v;
    logic [EW-1:0] st_wr_c, st_rd_c;
    logic [VW-1:0] stk_v_mem [MAX_VERTICES];
    logic [EW-1:0] stk_c_mem [MAX_VERTICES];
    logic [VW-1:0] stk_v_reg;
    logic [EW-1:0] stk_c_reg;

    logic       s_accept;
    logic       can_emit;
    logic [6:0] cnt;
    logic [1:0] in_kind;
    logic [4:0] in_from, in_to, in_start;
    logic       in_both;
    logic       cfg_wr;
    logic       t_ok;
    logic       emit_stall;
    logic [VW-1:0] visit_v;

    assign in_kind  = s_tuser;
    assign in_from  = s_tdata[4:0];
    assign in_to    = s_tdata[9:5];
    assign in_both  = s_tdata[10];
    assign in_start = s_tdata[15:11];

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign can_emit = !out_vld_reg || m_tready;
    assign cnt      = ({1'b0, vcount_reg} < MAXV7) ? {1'b0, vcount_reg} : MAXV7;

    // edge target usable: in range, not seen, room on the stack
    assign t_ok = (7'(ed_rd_tgt) < cnt) && !vis_reg[ed_rd_tgt] && (depth_reg < MAXV_D);
    assign visit_v = (state_reg == S_T1_VERT) ? stk_v_reg : ed_rd_tgt;
    assign emit_stall = (n_reg < LIM) && pend_vld_reg && !can_emit;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_MODE) ? {31'd0, mode_reg} : {26'd0, vcount_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VCOUNT_RESET;
            mode_reg   <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MODE) begin
                mode_reg <= pwdata[0];
            end else begin
                vcount_reg <= pwdata[5:0];
            end
        end
    end

    gdfs_head_mem #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_EDGES   (MAX_EDGES),
        .VW          (VW),
        .EW          (EW)
    ) u_head (
        .aclk   (aclk),
        .aresetn(aresetn),
        .clr    (hd_clr),
        .wr_en  (hd_wr_en),
        .wr_addr(hd_wr_addr),
        .wr_data(hd_wr_data),
        .rd_en  (hd_rd_en),
        .rd_addr(hd_rd_addr),
        .rd_data(hd_rd_data)
    );

    gdfs_edge_mem #(
        .MAX_EDGES(MAX_EDGES),
        .VW       (VW),
        .EW       (EW),
        .AW       (EAW)
    ) u_edge (
        .aclk   (aclk),
        .wr_en  (ed_wr_en),
        .wr_addr(ed_wr_addr),
        .wr_tgt (ed_wr_tgt),
        .wr_lnk (ed_wr_lnk),
        .rd_en  (ed_rd_en),
        .rd_addr(ed_rd_addr),
        .rd_tgt (ed_rd_tgt),
        .rd_lnk (ed_rd_lnk)
    );

    // walk stack memory
    always_ff @(posedge aclk) begin
        if (st_wr_en) begin
            stk_v_mem[st_wr_addr] <= st_wr_v;
            stk_c_mem[st_wr_addr] <= st_wr_c;
        end
        if (st_rd_en) begin
            stk_v_reg <= stk_v_mem[st_rd_addr];
            stk_c_reg <= stk_c_mem[st_rd_addr];
        end
    end
    assign st_rd_v = stk_v_reg;
    assign st_rd_c = stk_c_reg;

    always_comb begin
        state_next    = state_reg;
        used_next     = used_reg;
        depth_next    = depth_reg;
        cur_next      = cur_reg;
        vis_next      = vis_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        n_next        = n_reg;
        status_next   = status_reg;
        flush_next    = flush_reg;
        afrom_next    = afrom_reg;
        ato_next      = ato_reg;
        both_next     = both_reg;

        out_vld_next   = out_vld_reg && !m_tready;
        out_visit_next = out_visit_reg;
        out_v_next     = out_v_reg;
        out_last_next  = out_last_reg;
        out_st_next    = out_st_reg;

        hd_clr     = 1'b0;
        hd_wr_en   = 1'b0;
        hd_wr_addr = afrom_reg;
        hd_wr_data = used_reg;
        hd_rd_en   = 1'b0;
        hd_rd_addr = VW'(in_from);
        ed_wr_en   = 1'b0;
        ed_wr_addr = EAW'(used_reg);
        ed_wr_tgt  = ato_reg;
        ed_wr_lnk  = hd_rd_data;
        ed_rd_en   = 1'b0;
        ed_rd_addr = EAW'(cur_reg);
        st_wr_en   = 1'b0;
        st_wr_addr = VW'(depth_reg);
        st_wr_v    = ed_rd_tgt;
        st_wr_c    = ed_rd_lnk;
        st_rd_en   = 1'b0;
        st_rd_addr = VW'(depth_reg - DW'(1));

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    status_next = ST_OK;
                    flush_next  = 1'b0;
                    state_next  = S_ACK;
                    priority if (in_kind == KIND_ADD) begin
                        afrom_next = VW'(in_from);
                        ato_next   = VW'(in_to);
                        both_next  = in_both;
                        if ((7'(in_from) >= cnt) || (7'(in_to) >= cnt)) begin
                            status_next = ST_RANGE;
                        end else if (({1'b0, used_reg} + (in_both ? (EW+1)'(2) : (EW+1)'(1)))
                                     > MAXE_X) begin
                            status_next = ST_FULL;
                        end else begin
                            hd_rd_en   = 1'b1;
                            hd_rd_addr = VW'(in_from);
                            state_next = S_ADD_WR1;
                        end
                    end else if (in_kind == KIND_WALK) begin
                        if (7'(in_start) >= cnt) begin
                            status_next = ST_RANGE;
                        end else begin
                            vis_next = '0;
                            vis_next[VW'(in_start)] = 1'b1;
                            depth_next = DW'(1);
                            if (!mode_reg) begin
                                pend_next     = VW'(in_start);
                                pend_vld_next = 1'b1;
                                n_next        = 6'd1;
                                hd_rd_en      = 1'b1;
                                hd_rd_addr    = VW'(in_start);
                                state_next    = S_T0_HEAD;
                            end else begin
                                pend_vld_next = 1'b0;
                                n_next        = 6'd0;
                                st_wr_en      = 1'b1;
                                st_wr_addr    = '0;
                                st_wr_v       = VW'(in_start);
                                state_next    = S_T1_POP;
                            end
                        end
                    end else if (in_kind == KIND_CLEAR) begin
                        hd_clr    = 1'b1;
                        used_next = '0;
                    end else begin
                        status_next = ST_OK;
                    end
                end
            end
            S_ADD_WR1: begin
                ed_wr_en   = 1'b1;
                ed_wr_tgt  = ato_reg;
                hd_wr_en   = 1'b1;
                hd_wr_addr = afrom_reg;
                used_next  = used_reg + EW'(1);
                state_next = both_reg ? S_ADD_RD2 : S_ACK;
            end
            S_ADD_RD2: begin
                hd_rd_en   = 1'b1;
                hd_rd_addr = ato_reg;
                state_next = S_ADD_WR2;
            end
            S_ADD_WR2: begin
                ed_wr_en   = 1'b1;
                ed_wr_tgt  = afrom_reg;
                hd_wr_en   = 1'b1;
                hd_wr_addr = ato_reg;
                used_next  = used_reg + EW'(1);
                state_next = S_ACK;
            end
            S_ACK: begin
                if (can_emit) begin
                    out_vld_next = 1'b1;
                    out_last_next = 1'b1;
                    if (flush_reg) begin
                        out_visit_next = 1'b1;
                        out_v_next     = 5'(pend_reg);
                        out_st_next    = ST_OK;
                    end else begin
                        out_visit_next = 1'b0;
                        out_v_next     = 5'd0;
                        out_st_next    = status_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            S_T0_CUR: begin
                if (cur_reg == NULL_EDGE) begin
                    depth_next = depth_reg - DW'(1);
                    if (depth_reg == DW'(1)) begin
                        flush_next = 1'b1;
                        state_next = S_ACK;
                    end else begin
                        st_rd_en   = 1'b1;
                        st_rd_addr = VW'(depth_reg - DW'(2));
                        state_next = S_T0_POP;
                    end
                end else begin
                    ed_rd_en   = 1'b1;
                    state_next = S_T0_EDGE;
                end
            end
            S_T0_EDGE: begin
                if (!t_ok) begin
                    cur_next   = ed_rd_lnk;
                    state_next = S_T0_CUR;
                end else if (!emit_stall) begin
                    vis_next[ed_rd_tgt] = 1'b1;
                    st_wr_en   = 1'b1;
                    st_wr_addr = VW'(depth_reg - DW'(1));
                    st_wr_c    = ed_rd_lnk;
                    depth_next = depth_reg + DW'(1);
                    hd_rd_en   = 1'b1;
                    hd_rd_addr = ed_rd_tgt;
                    state_next = S_T0_HEAD;
                end
            end
            S_T0_HEAD: begin
                cur_next   = hd_rd_data;
                state_next = S_T0_CUR;
            end
            S_T0_POP: begin
                cur_next   = st_rd_c;
                state_next = S_T0_CUR;
            end
            S_T1_POP: begin
                depth_next = depth_reg - DW'(1);
                st_rd_en   = 1'b1;
                st_rd_addr = VW'(depth_reg - DW'(1));
                state_next = S_T1_VERT;
            end
            S_T1_VERT: begin
                if (!emit_stall) begin
                    hd_rd_en   = 1'b1;
                    hd_rd_addr = st_rd_v;
                    state_next = S_T1_HEAD;
                end
            end
            S_T1_HEAD: begin
                cur_next   = hd_rd_data;
                state_next = S_T1_CUR;
            end
            S_T1_CUR: begin
                if (cur_reg == NULL_EDGE) begin
                    if (depth_reg == '0) begin
                        flush_next = 1'b1;
                        state_next = S_ACK;
                    end else begin
                        state_next = S_T1_POP;
                    end
                end else begin
                    ed_rd_en   = 1'b1;
                    state_next = S_T1_EDGE;
                end
            end
            S_T1_EDGE: begin
                cur_next = ed_rd_lnk;
                if (t_ok) begin
                    vis_next[ed_rd_tgt] = 1'b1;
                    st_wr_en   = 1'b1;
                    st_wr_addr = VW'(depth_reg);
                    st_wr_v    = ed_rd_tgt;
                    depth_next = depth_reg + DW'(1);
                end
                state_next = S_T1_CUR;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // a new visit pushes the held one out, the last is held until the end
        if (((state_reg == S_T0_EDGE) && t_ok && !emit_stall)
            || ((state_reg == S_T1_VERT) && !emit_stall)) begin
            if (n_reg < LIM) begin
                if (pend_vld_reg) begin
                    out_vld_next   = 1'b1;
                    out_visit_next = 1'b1;
                    out_v_next     = 5'(pend_reg);
                    out_last_next  = 1'b0;
                    out_st_next    = ST_OK;
                end
                pend_next     = visit_v;
                pend_vld_next = 1'b1;
                n_next        = n_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            depth_reg    <= '0;
            vis_reg      <= '0;
            pend_vld_reg <= 1'b0;
            n_reg        <= '0;
            flush_reg    <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            depth_reg    <= depth_next;
            vis_reg      <= vis_next;
            pend_vld_reg <= pend_vld_next;
            n_reg        <= n_next;
            flush_reg    <= flush_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        pend_reg      <= pend_next;
        status_reg    <= status_next;
        afrom_reg     <= afrom_next;
        ato_reg       <= ato_next;
        both_reg      <= both_next;
        out_visit_reg <= out_visit_next;
        out_v_reg     <= out_v_next;
        out_last_reg  <= out_last_next;
        out_st_reg    <= out_st_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_st_reg, out_v_reg};
    assign m_tuser  = out_visit_reg;
    assign m_tlast  = out_last_reg;

    `GDFS_ASSERT_ALWAYS(a_depth_bound, depth_reg <= MAXV_D)
    `GDFS_ASSERT_ALWAYS(a_used_bound, {1'b0, used_reg} <= MAXE_X)
    `GDFS_ASSERT_NEXT(a_busy_after_request, s_accept, !s_tready)
    `GDFS_ASSERT_IMPL(a_flush_has_vertex, (state_reg == S_ACK) && flush_reg, pend_vld_reg)

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking bench for the depth-first search block: adds, clears and walks
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import gdfs_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int NO_EDGE = MAX_EDGES_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] src;
        logic [4:0] dst;
        logic       both_ways;
        logic [4:0] start_vtx;
    } request_t;

    typedef struct packed {
        logic       visit;
        logic [4:0] vertex;
        logic       last;
        logic [1:0] status;
    } visit_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    graph_depth_first_search dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow copy of the graph
    int graph_vcount;
    int graph_mode;
    int list_head_q[MAX_VERTICES_DEF];
    int edge_dst_q[MAX_EDGES_DEF];
    int edge_next_q[MAX_EDGES_DEF];
    int edges_in_use;

    request_t pending_requests[$];
    visit_t   expected_visits[$];
    request_t driven_request;

    int errors;
    int burst_left;
    int gap_left;
    int stall_idx;
    logic [15:0] stall_pat;
    int quiet_cycles;

    always #1 aclk = ~aclk;

    function automatic int live_count();
        return graph_vcount < MAX_VERTICES_DEF ? graph_vcount : MAX_VERTICES_DEF;
    endfunction

    function automatic void push_ack(logic [1:0] st);
        visit_t v;
        v = '{visit: 1'b0, vertex: 5'd0, last: 1'b1, status: st};
        expected_visits.push_back(v);
    endfunction

    function automatic void link_edge(int from_v, int to_v);
        edge_dst_q[edges_in_use] = to_v;
        edge_next_q[edges_in_use] = list_head_q[from_v];
        list_head_q[from_v] = edges_in_use;
        edges_in_use++;
    endfunction

    function automatic void walk_graph(int start_v, int cnt);
        visit_t order[$];
        visit_t v;
        bit     seen[MAX_VERTICES_DEF];
        int     stk_v[MAX_VERTICES_DEF];
        int     stk_c[MAX_VERTICES_DEF];
        int     depth;
        int     top;
        int     cur;
        int     t;
        for (int i = 0; i < MAX_VERTICES_DEF; i++) seen[i] = 0;
        seen[start_v] = 1;
        v = '{visit: 1'b1, vertex: 5'd0, last: 1'b0, status: ST_OK};
        if (graph_mode == 0) begin
            v.vertex = start_v[4:0];
            order.push_back(v);
            stk_v[0] = start_v;
            stk_c[0] = list_head_q[start_v];
            depth = 1;
            while (depth > 0) begin
                top = depth - 1;
                cur = stk_c[top];
                if (cur >= NO_EDGE) begin
                    depth--;
                    continue;
                end
                t = edge_dst_q[cur];
                stk_c[top] = edge_next_q[cur];
                if (t < cnt && !seen[t] && depth < MAX_VERTICES_DEF) begin
                    seen[t] = 1;
                    v.vertex = t[4:0];
                    order.push_back(v);
                    stk_v[depth] = t;
                    stk_c[depth] = list_head_q[t];
                    depth++;
                end
            end
        end else begin
            stk_v[0] = start_v;
            depth = 1;
            while (depth > 0) begin
                depth--;
                top = stk_v[depth] % MAX_VERTICES_DEF;
                v.vertex = top[4:0];
                order.push_back(v);
                for (cur = list_head_q[top]; cur < NO_EDGE; cur = edge_next_q[cur]) begin
                    t = edge_dst_q[cur];
                    if (t < cnt && !seen[t] && depth < MAX_VERTICES_DEF) begin
                        seen[t] = 1;
                        stk_v[depth] = t;
                        depth++;
                    end
                end
            end
        end
        while (order.size() > OUT_LIMIT) void'(order.pop_back());
        order[order.size() - 1].last = 1'b1;
        foreach (order[i]) expected_visits.push_back(order[i]);
    endfunction

    function automatic void predict_request(request_t r);
        int cnt;
        int need;
        cnt = live_count();
        case (r.kind)
            KIND_ADD: begin
                need = r.both_ways ? 2 : 1;
                if (r.src >= cnt || r.dst >= cnt) begin
                    push_ack(ST_RANGE);
                end else if (edges_in_use + need > MAX_EDGES_DEF) begin
                    push_ack(ST_FULL);
                end else begin
                    link_edge(r.src, r.dst);
                    if (r.both_ways) link_edge(r.dst, r.src);
                    push_ack(ST_OK);
                end
            end
            KIND_WALK: begin
                if (r.start_vtx >= cnt) push_ack(ST_RANGE);
                else walk_graph(r.start_vtx, cnt);
            end
            KIND_CLEAR: begin
                for (int i = 0; i < MAX_VERTICES_DEF; i++) list_head_q[i] = NO_EDGE;
                edges_in_use = 0;
                push_ack(ST_OK);
            end
            default: push_ack(ST_OK);
        endcase
    endfunction

    // sender: bursts of requests with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            burst_left <= 4;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) predict_request(driven_request);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    driven_request = pending_requests.pop_front();
                    s_tdata <= {driven_request.start_vtx, driven_request.both_ways,
                                driven_request.dst, driven_request.src};
                    s_tuser <= driven_request.kind;
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall pattern, reloaded once all of its bits are used
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_idx <= 0;
            stall_pat <= 16'hffff;
        end else begin
            m_tready <= stall_pat[stall_idx];
            if (stall_idx == 15) begin
                stall_idx <= 0;
                stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hffff
                                                         : (16'($urandom) | 16'h0101);
            end else begin
                stall_idx <= stall_idx + 1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        visit_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_visits.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: visit %0d vertex %0d last %0d status %0d",
                             m_tuser[0], m_tdata[4:0], m_tlast, m_tdata[6:5]);
            end else begin
                want = expected_visits.pop_front();
                if (m_tuser[0] !== want.visit || m_tdata[4:0] !== want.vertex ||
                    m_tlast !== want.last || m_tdata[6:5] !== want.status) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected v%0d n%0d l%0d s%0d, got v%0d n%0d l%0d s%0d",
                                 want.visit, want.vertex, want.last, want.status,
                                 m_tuser[0], m_tdata[4:0], m_tlast, m_tdata[6:5]);
                end
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic queue_request(logic [1:0] kind, int src, int dst, bit both, int start_v);
        request_t r;
        r.kind = kind;
        r.src = src[4:0];
        r.dst = dst[4:0];
        r.both_ways = both;
        r.start_vtx = start_v[4:0];
        pending_requests.push_back(r);
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_requests.size() != 0 || s_tvalid || expected_visits.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic index, int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index == REG_VCOUNT) graph_vcount = value & 63;
        else graph_mode = value & 1;
    endtask

    task automatic set_config(int vcount, int mode);
        wait_drained();
        write_reg(REG_VCOUNT, vcount);
        write_reg(REG_MODE, mode);
        @(posedge aclk);
    endtask

    // random phase: mostly edges in range, some walks, a few clears and junk
    task automatic random_phase(int n_items, int add_weight);
        int cnt;
        int pick;
        int hi;
        cnt = live_count();
        hi = (cnt == 0) ? 0 : cnt - 1;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < add_weight) begin
                if ($urandom_range(0, 9) == 0)
                    queue_request(KIND_ADD, $urandom_range(0, 31), $urandom_range(0, 31),
                                  $urandom_range(0, 1), $urandom_range(0, 31));
                else
                    queue_request(KIND_ADD, $urandom_range(0, hi), $urandom_range(0, hi),
                                  $urandom_range(0, 1), $urandom_range(0, 31));
            end else if (pick < 94) begin
                queue_request(KIND_WALK, $urandom_range(0, 31), $urandom_range(0, 31), 1'b0,
                              ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                          : $urandom_range(0, hi));
            end else if (pick < 97) begin
                queue_request(KIND_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31),
                              $urandom_range(0, 1), $urandom_range(0, 31));
            end else begin
                queue_request(KIND_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
                              $urandom_range(0, 1), $urandom_range(0, 31));
            end
        end
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        quiet_cycles = 0;
        graph_vcount = VCOUNT_RESET;
        graph_mode = 0;
        edges_in_use = 0;
        for (int i = 0; i < MAX_VERTICES_DEF; i++) list_head_q[i] = NO_EDGE;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part, reset settings: preorder walks with all 32 vertices in range
        queue_request(KIND_WALK, 0, 0, 0, 31);
        queue_request(KIND_ADD, 0, 31, 1, 0);
        queue_request(KIND_ADD, 31, 5, 0, 0);
        queue_request(KIND_ADD, 5, 5, 0, 0);
        queue_request(KIND_ADD, 0, 1, 1, 0);
        queue_request(KIND_ADD, 1, 2, 0, 0);
        queue_request(KIND_ADD, 2, 30, 1, 0);
        queue_request(KIND_WALK, 31, 31, 1, 0);
        queue_request(KIND_WALK, 0, 0, 0, 31);
        queue_request(KIND_UNUSED, 31, 31, 1, 31);
        set_config(4, 1);
        // lower count leaves stale edges behind
        queue_request(KIND_WALK, 0, 0, 0, 0);
        queue_request(KIND_ADD, 3, 10, 0, 0);
        queue_request(KIND_ADD, 10, 3, 0, 0);
        queue_request(KIND_WALK, 0, 0, 0, 9);
        queue_request(KIND_ADD, 3, 2, 1, 0);
        queue_request(KIND_WALK, 0, 0, 0, 3);
        set_config(0, 0);
        queue_request(KIND_ADD, 0, 0, 0, 0);
        queue_request(KIND_WALK, 0, 0, 0, 0);
        set_config(63, 1);
        queue_request(KIND_WALK, 0, 0, 0, 0);
        queue_request(KIND_CLEAR, 0, 0, 0, 0);
        queue_request(KIND_WALK, 0, 0, 0, 7);
        set_config(1, 0);
        queue_request(KIND_ADD, 0, 0, 1, 0);
        queue_request(KIND_WALK, 0, 0, 0, 0);

        // fill the edge store to the brim, then walk the dense graph
        set_config(32, 0);
        queue_request(KIND_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < 170; i++)
            queue_request(KIND_ADD, $urandom_range(0, 31), $urandom_range(0, 31),
                          (i % 3) != 0, 0);
        queue_request(KIND_ADD, 1, 2, 1, 0);
        queue_request(KIND_ADD, 1, 2, 0, 0);
        queue_request(KIND_WALK, 0, 0, 0, $urandom_range(0, 31));
        set_config(32, 1);
        queue_request(KIND_WALK, 0, 0, 0, $urandom_range(0, 31));
        queue_request(KIND_CLEAR, 0, 0, 0, 0);

        // random phases with fresh settings
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 5))
                0: set_config(1, $urandom_range(0, 1));
                1: set_config(2, $urandom_range(0, 1));
                2: set_config(63, $urandom_range(0, 1));
                3: set_config(32, $urandom_range(0, 1));
                default: set_config($urandom_range(1, 32), $urandom_range(0, 1));
            endcase
            random_phase(22, 70);
        end
        wait_drained();

        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
